// ===== rtl/core/hsv_pkg.sv =====
package hsv_pkg;

   localparam int ChanCount   = 3;
   localparam int ChanWidth   = 8;
   localparam int HueWidth    = 9;
   localparam int HueWrap     = 360;
   localparam int SectorDeg   = 60;
   localparam int SectorCount = 6;
   localparam int SecWidth    = 3;
   localparam int ResWidth    = 6;
   localparam int SpanWidth   = 7;
   localparam int LevelFull   = 255 * 60;
   localparam int LevelWidth  = 14;
   localparam int DropWidth   = 15;
   localparam int ProdWidth   = 22;
   localparam int RecipShift  = 24;
   localparam int RecipMul    = (1 << RecipShift) / LevelFull;
   localparam int RecipWidth  = 11;
   localparam int EstWidth    = ProdWidth + RecipWidth;

   localparam logic [1:0] ChRed   = 2'd0;
   localparam logic [1:0] ChGreen = 2'd1;
   localparam logic [1:0] ChBlue  = 2'd2;

   typedef enum logic [SecWidth-1:0] {
      SEC_RED,
      SEC_YELLOW,
      SEC_GREEN,
      SEC_CYAN,
      SEC_BLUE,
      SEC_MAGENTA
   } sector_type;

   typedef enum logic [1:0] {
      ROLE_ZERO,
      ROLE_FULL,
      ROLE_RISE,
      ROLE_FALL
   } role_type;

   typedef logic [ChanWidth-1:0]  chan_type;
   typedef logic [LevelWidth-1:0] level_type;
   typedef logic [ProdWidth-1:0]  prod_type;

   // what a channel does inside each hue sector
   function automatic role_type chan_role(sector_type sec, logic [1:0] ch);
      role_type role;
      role = ROLE_ZERO;
      unique case (sec)
         SEC_RED:     role = (ch == ChRed)   ? ROLE_FULL :
                             (ch == ChGreen) ? ROLE_RISE : ROLE_ZERO;
         SEC_YELLOW:  role = (ch == ChRed)   ? ROLE_FALL :
                             (ch == ChGreen) ? ROLE_FULL : ROLE_ZERO;
         SEC_GREEN:   role = (ch == ChRed)   ? ROLE_ZERO :
                             (ch == ChGreen) ? ROLE_FULL : ROLE_RISE;
         SEC_CYAN:    role = (ch == ChRed)   ? ROLE_ZERO :
                             (ch == ChGreen) ? ROLE_FALL : ROLE_FULL;
         SEC_BLUE:    role = (ch == ChRed)   ? ROLE_RISE :
                             (ch == ChGreen) ? ROLE_ZERO : ROLE_FULL;
         SEC_MAGENTA: role = (ch == ChRed)   ? ROLE_FULL :
                             (ch == ChGreen) ? ROLE_ZERO : ROLE_FALL;
         default:     role = ROLE_ZERO;
      endcase
      return role;
   endfunction

endpackage

// ===== rtl/core/hsv_sector.sv =====
module hsv_sector (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   output logic                           in_stall,
   input  logic [hsv_pkg::HueWidth-1:0]   hue,
   input  logic [hsv_pkg::ChanWidth-1:0]  sat,
   input  logic [hsv_pkg::ChanWidth-1:0]  bri,
   output logic                           out_valid,
   input  logic                           out_stall,
   output hsv_pkg::sector_type            sector,
   output logic [hsv_pkg::ResWidth-1:0]   residue,
   output logic [hsv_pkg::ChanWidth-1:0]  sat_out,
   output logic [hsv_pkg::ChanWidth-1:0]  bri_out
);
   import hsv_pkg::*;

   logic                  valid_ff;
   logic                  advance;
   logic [HueWidth-1:0]   hue_wrap;
   logic [SecWidth-1:0]   sec_count;
   sector_type            sector_in, sector_ff;
   logic [ResWidth-1:0]   residue_in, residue_ff;
   logic [ChanWidth-1:0]  sat_ff, bri_ff;

   assign advance  = !valid_ff || !out_stall;
   assign in_stall = !advance;

   always_comb begin
      hue_wrap = (hue >= HueWidth'(HueWrap)) ? hue - HueWidth'(HueWrap) : hue;
      sec_count = '0;
      for (int i = 1; i < SectorCount; i++) begin
         if (hue_wrap >= HueWidth'(i * SectorDeg)) begin
            sec_count = sec_count + SecWidth'(1);
         end
      end
      residue_in = ResWidth'(hue_wrap - HueWidth'(sec_count * SectorDeg));
      sector_in  = sector_type'(sec_count);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
      if (advance) begin
         sector_ff  <= sector_in;
         residue_ff <= residue_in;
         sat_ff     <= sat;
         bri_ff     <= bri;
      end
   end

   assign out_valid = valid_ff;
   assign sector    = sector_ff;
   assign residue   = residue_ff;
   assign sat_out   = sat_ff;
   assign bri_out   = bri_ff;

endmodule

// ===== rtl/core/hsv_level.sv =====
module hsv_level (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   output logic                           in_stall,
   input  hsv_pkg::sector_type            sector,
   input  logic [hsv_pkg::ResWidth-1:0]   residue,
   input  logic [hsv_pkg::ChanWidth-1:0]  sat,
   input  logic [hsv_pkg::ChanWidth-1:0]  bri,
   output logic                           out_valid,
   input  logic                           out_stall,
   output hsv_pkg::prod_type              prod [hsv_pkg::ChanCount]
);
   import hsv_pkg::*;

   logic                  valid_a_ff, valid_b_ff;
   logic                  adv_a, adv_b;
   level_type             level_in [ChanCount];
   level_type             level_ff [ChanCount];
   logic [ChanWidth-1:0]  bri_ff;
   prod_type              prod_in [ChanCount];
   prod_type              prod_ff [ChanCount];
   role_type              role [ChanCount];
   logic [SpanWidth-1:0]  span [ChanCount];
   logic [SpanWidth-1:0]  gap [ChanCount];
   logic [DropWidth-1:0]  drop [ChanCount];

   assign adv_b    = !valid_b_ff || !out_stall;
   assign adv_a    = !valid_a_ff || adv_b;
   assign in_stall = !adv_a;

   // channel level scaled by 60: full minus the saturation pull; the registered level is then multiplied by brightness
   always_comb begin
      for (int c = 0; c < ChanCount; c++) begin
         role[c] = chan_role(sector, 2'(c));
         unique case (role[c])
            ROLE_ZERO: span[c] = '0;
            ROLE_FULL: span[c] = SpanWidth'(SectorDeg);
            ROLE_RISE: span[c] = SpanWidth'(residue);
            ROLE_FALL: span[c] = SpanWidth'(SectorDeg) - SpanWidth'(residue);
            default:   span[c] = '0;
         endcase
         gap[c]      = SpanWidth'(SectorDeg) - span[c];
         drop[c]     = DropWidth'(gap[c]) * DropWidth'(sat);
         level_in[c] = LevelWidth'(LevelFull) - LevelWidth'(drop[c]);
         prod_in[c]  = ProdWidth'(level_ff[c]) * ProdWidth'(bri_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
         valid_b_ff <= 1'b0;
      end else begin
         if (adv_a) begin
            valid_a_ff <= in_valid;
         end
         if (adv_b) begin
            valid_b_ff <= valid_a_ff;
         end
      end
      if (adv_a) begin
         level_ff <= level_in;
         bri_ff   <= bri;
      end
      if (adv_b) begin
         prod_ff <= prod_in;
      end
   end

   assign out_valid = valid_b_ff;
   assign prod      = prod_ff;

endmodule

// ===== rtl/core/hsv_div.sv =====
module hsv_div (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_stall,
   input  hsv_pkg::prod_type  prod [hsv_pkg::ChanCount],
   output logic               out_valid,
   input  logic               out_stall,
   output hsv_pkg::chan_type  chan [hsv_pkg::ChanCount]
);
   import hsv_pkg::*;

   logic                  valid_a_ff, valid_b_ff;
   logic                  adv_a, adv_b;
   logic [EstWidth-1:0]   est [ChanCount];
   chan_type              quot_ff [ChanCount];
   prod_type              prod_ff [ChanCount];
   prod_type              back [ChanCount];
   prod_type              rem [ChanCount];
   chan_type              chan_in [ChanCount];
   chan_type              chan_ff [ChanCount];

   assign adv_b    = !valid_b_ff || !out_stall;
   assign adv_a    = !valid_a_ff || adv_b;
   assign in_stall = !adv_a;

   // divide by 15300: reciprocal estimate is exact or one short
   always_comb begin
      for (int c = 0; c < ChanCount; c++) begin
         est[c]     = EstWidth'(prod[c]) * EstWidth'(RecipMul);
         back[c]    = ProdWidth'(quot_ff[c]) * ProdWidth'(LevelFull);
         rem[c]     = prod_ff[c] - back[c];
         chan_in[c] = quot_ff[c] + ChanWidth'(rem[c] >= ProdWidth'(LevelFull));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
         valid_b_ff <= 1'b0;
      end else begin
         if (adv_a) begin
            valid_a_ff <= in_valid;
         end
         if (adv_b) begin
            valid_b_ff <= valid_a_ff;
         end
      end
      if (adv_a) begin
         for (int c = 0; c < ChanCount; c++) begin
            quot_ff[c] <= est[c][RecipShift +: ChanWidth];
            prod_ff[c] <= prod[c];
         end
      end
      if (adv_b) begin
         chan_ff <= chan_in;
      end
   end

   assign out_valid = valid_b_ff;
   assign chan      = chan_ff;

endmodule

// ===== rtl/core/hsv_to_rgb_integer.sv =====
// HSV to 8-bit RGB converter. Takes one request per clock while req_stall is
// low and returns each result in order through its stages (sector decode,
// saturation pull, brightness multiply, two-stage divide by 15300). rsp_stall
// holds the whole pipeline; bubbles close up, so req_stall rises only once
// every stage holds a request. Hue values from 360 to 511 wrap modulo 360.
module hsv_to_rgb_integer (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [hsv_pkg::HueWidth-1:0]   req_hue_deg,
   input  logic [hsv_pkg::ChanWidth-1:0]  req_saturation,
   input  logic [hsv_pkg::ChanWidth-1:0]  req_brightness,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [hsv_pkg::ChanWidth-1:0]  rsp_red_out,
   output logic [hsv_pkg::ChanWidth-1:0]  rsp_green_out,
   output logic [hsv_pkg::ChanWidth-1:0]  rsp_blue_out
);
   import hsv_pkg::*;

   logic                  sec_valid, sec_stall;
   sector_type            sector;
   logic [ResWidth-1:0]   residue;
   logic [ChanWidth-1:0]  sec_sat, sec_bri;
   logic                  lvl_valid, lvl_stall;
   prod_type              prod [ChanCount];
   chan_type              chan [ChanCount];

   hsv_sector u_sector (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .hue       (req_hue_deg),
      .sat       (req_saturation),
      .bri       (req_brightness),
      .out_valid (sec_valid),
      .out_stall (sec_stall),
      .sector    (sector),
      .residue   (residue),
      .sat_out   (sec_sat),
      .bri_out   (sec_bri)
   );

   hsv_level u_level (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sec_valid),
      .in_stall  (sec_stall),
      .sector    (sector),
      .residue   (residue),
      .sat       (sec_sat),
      .bri       (sec_bri),
      .out_valid (lvl_valid),
      .out_stall (lvl_stall),
      .prod      (prod)
   );

   hsv_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (lvl_valid),
      .in_stall  (lvl_stall),
      .prod      (prod),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .chan      (chan)
   );

   assign rsp_red_out   = chan[ChRed];
   assign rsp_green_out = chan[ChGreen];
   assign rsp_blue_out  = chan[ChBlue];

endmodule
